@@ src/mtrwg_pkg.sv @@
// Package with the types, constants and helper functions of the MT19937 word generator.
package mtrwg_pkg;

  localparam int STATE_WORDS      = 624;
  localparam int TWIST_OFFSET     = 397;
  localparam int WARMUP_DRAWS_DEF = 37;
  localparam int IDX_W            = 10;
  localparam int INIT_SHIFT       = 30;

  localparam logic [31:0] INIT_MULT  = 32'd1812433253;
  localparam logic [31:0] MATRIX_A   = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B   = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C   = 32'hEFC6_0000;

  localparam logic REQ_SEED = 1'b0;
  localparam logic REQ_DRAW = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] seed_value;
    logic        [26:0] tick_value;
  } mtrwg_req_t;

  typedef struct packed {
    logic [31:0] random_word;
    logic        not_seeded;
  } mtrwg_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_FILL,
    ST_WARM,
    ST_TW_P0,
    ST_TW_P1,
    ST_TW_RUN,
    ST_DRAW_RD,
    ST_DRAW_OUT
  } mtrwg_state_t;

  function automatic logic [31:0] mix_pair(input logic [31:0] hi_word,
                                           input logic [31:0] lo_word,
                                           input logic [31:0] far_word);
    logic [31:0] y;
    logic [31:0] r;
    y = {hi_word[31], lo_word[30:0]};
    r = far_word ^ (y >> 1);
    if (y[0]) begin
      r = r ^ MATRIX_A;
    end
    return r;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] y;
    y = w ^ (w >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic idx_t wrap_add(input idx_t base, input int unsigned step);
    logic [IDX_W:0] s;
    s = {1'b0, base} + (IDX_W + 1)'(step);
    if (s >= (IDX_W + 1)'(STATE_WORDS)) begin
      s = s - (IDX_W + 1)'(STATE_WORDS);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

@@ src/mt19937_random_word_generator.sv @@
// Top level of the MT19937 random word generator with its state memory and sequencer.
//
//   channel  direction  payload        handshake
//   in_      input      mtrwg_req_t    in_valid / in_ready
//   out_     output     mtrwg_res_t    out_valid / out_ready
//
// A draw passes through ST_DRAW_RD and ST_DRAW_OUT; when the state block must be twisted
// first, ST_TW_P0 and ST_TW_P1 prime the reads, then ST_TW_RUN writes one word per cycle.
// A seed fills the block, twists it, then steps past WARMUP_DRAWS words before going idle.
// Reset is synchronous; it sets the read index to the block end and clears the seeded flag, not the store.
// A waiting result does not block acceptance; a finished draw holds until the output frees.
module mt19937_random_word_generator #(
  parameter int WARMUP_DRAWS = mtrwg_pkg::WARMUP_DRAWS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mtrwg_pkg::mtrwg_req_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mtrwg_pkg::mtrwg_res_t out_data
);
  import mtrwg_pkg::*;

  localparam int WCNT_W = (WARMUP_DRAWS > 0) ? $clog2(WARMUP_DRAWS + 1) : 1;
  localparam idx_t IDX_END = IDX_W'(STATE_WORDS);

  mtrwg_state_t state_r, state_nxt;

  idx_t              idx_r, idx_nxt;
  idx_t              k_r, k_nxt;
  logic [31:0]       p_r, p_nxt;
  logic [31:0]       cur_r;
  logic              seeded_r, seeded_nxt;
  logic              mode_warm_r, mode_warm_nxt;
  logic [WCNT_W-1:0] warm_cnt_r, warm_cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  mtrwg_res_t        out_data_r, out_data_nxt;

  logic [31:0] mem [STATE_WORDS];
  logic        mem_we;
  idx_t        mem_wa, mem_ra, mem_rb;
  logic [31:0] mem_wd, rd_a, rd_b;

  logic [31:0] seed_word;
  logic [31:0] fill_mix;
  logic [31:0] fill_prod;
  logic        out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  assign seed_word = in_data.seed_value[31] ? {5'b0, in_data.tick_value}
                                            : in_data.seed_value;
  assign fill_mix  = p_r ^ (p_r >> INIT_SHIFT);
  assign fill_prod = fill_mix * INIT_MULT;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a <= mem[mem_ra];
    rd_b <= mem[mem_rb];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == REQ_SEED) begin
            state_nxt = ST_SEED_FILL;
          end else if (seeded_r && idx_r == IDX_END) begin
            state_nxt = ST_TW_P0;
          end else begin
            state_nxt = ST_DRAW_RD;
          end
        end
      end
      ST_SEED_FILL: begin
        if (k_r == IDX_END - 1'b1) begin
          state_nxt = ST_WARM;
        end
      end
      ST_WARM: begin
        if (warm_cnt_r == WCNT_W'(WARMUP_DRAWS)) begin
          state_nxt = ST_IDLE;
        end else if (idx_r == IDX_END) begin
          state_nxt = ST_TW_P0;
        end
      end
      ST_TW_P0:   state_nxt = ST_TW_P1;
      ST_TW_P1:   state_nxt = ST_TW_RUN;
      ST_TW_RUN: begin
        if (k_r == IDX_END - 1'b1) begin
          state_nxt = mode_warm_r ? ST_WARM : ST_DRAW_RD;
        end
      end
      ST_DRAW_RD: state_nxt = ST_DRAW_OUT;
      ST_DRAW_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    p_nxt         = p_r;
    seeded_nxt    = seeded_r;
    mode_warm_nxt = mode_warm_r;
    warm_cnt_nxt  = warm_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = k_r;
    mem_wd        = p_r;
    mem_ra        = idx_r;
    mem_rb        = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_data.req_type == REQ_SEED) begin
            mem_we = 1'b1;
            mem_wa = '0;
            mem_wd = seed_word;
            p_nxt  = seed_word;
            k_nxt  = IDX_W'(1);
          end else begin
            mode_warm_nxt = 1'b0;
          end
        end
      end
      ST_SEED_FILL: begin
        p_nxt  = fill_prod + {22'b0, k_r};
        mem_we = 1'b1;
        mem_wa = k_r;
        mem_wd = p_nxt;
        k_nxt  = k_r + 1'b1;
        if (k_r == IDX_END - 1'b1) begin
          idx_nxt       = IDX_END;
          seeded_nxt    = 1'b1;
          warm_cnt_nxt  = '0;
          mode_warm_nxt = 1'b1;
        end
      end
      ST_WARM: begin
        if (warm_cnt_r != WCNT_W'(WARMUP_DRAWS) && idx_r != IDX_END) begin
          idx_nxt      = idx_r + 1'b1;
          warm_cnt_nxt = warm_cnt_r + 1'b1;
        end
      end
      ST_TW_P0: begin
        mem_ra = '0;
        k_nxt  = '0;
      end
      ST_TW_P1: begin
        mem_ra = IDX_W'(1);
        mem_rb = IDX_W'(TWIST_OFFSET);
      end
      ST_TW_RUN: begin
        mem_ra = wrap_add(k_r, 2);
        mem_rb = wrap_add(k_r, TWIST_OFFSET + 1);
        mem_we = 1'b1;
        mem_wa = k_r;
        mem_wd = mix_pair(cur_r, rd_a, rd_b);
        k_nxt  = k_r + 1'b1;
        if (k_r == IDX_END - 1'b1) begin
          idx_nxt = '0;
        end
      end
      ST_DRAW_RD: begin
        mem_ra = idx_r;
      end
      ST_DRAW_OUT: begin
        mem_ra = idx_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (seeded_r) begin
            out_data_nxt.random_word = temper(rd_a);
            out_data_nxt.not_seeded  = 1'b0;
            idx_nxt                  = idx_r + 1'b1;
          end else begin
            out_data_nxt.random_word = '0;
            out_data_nxt.not_seeded  = 1'b1;
          end
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= IDX_END;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
      mode_warm_r <= 1'b0;
      warm_cnt_r  <= '0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      seeded_r    <= seeded_nxt;
      out_valid_r <= out_valid_nxt;
      mode_warm_r <= mode_warm_nxt;
      warm_cnt_r  <= warm_cnt_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    cur_r      <= rd_a;
    out_data_r <= out_data_nxt;
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= IDX_END)
    else $error("read index beyond the state block");

  a_seeded_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.not_seeded) |-> seeded_r)
    else $error("valid word delivered while not seeded");

  a_twist_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TW_RUN) |-> (mem_wa != mem_ra && mem_wa != mem_rb))
    else $error("twist write collides with a pending read");

  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.req_type == REQ_SEED) |=> !in_ready)
    else $error("input taken during a seed fill");

endmodule

@@ dv/tb_mt19937_random_word_generator.sv @@
// Self-checking testbench for the MT19937 random word generator: seeds, draws, stalls.
module tb_mt19937_random_word_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import mtrwg_pkg::*;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  mtrwg_req_t in_data;
  logic       out_valid;
  logic       out_ready;
  mtrwg_res_t out_data;

  mt19937_random_word_generator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  logic [31:0] gen_words [0:STATE_WORDS-1];
  int unsigned gen_pos;
  bit          gen_seeded;
  mtrwg_res_t  words_due [$];

  bit idle_on;
  int lead_gap;
  int hold_cycles;
  int errors;
  int n_draws;
  int n_seeds;
  int n_tick_seeds;
  int n_unseeded;
  int n_twists;
  int n_checked;

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic int idle_gap();
    int r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic void twist_all();
    logic [31:0] y;
    int nxt;
    int far;
    for (int k = 0; k < STATE_WORDS; k++) begin
      nxt = (k + 1) % STATE_WORDS;
      far = (k + TWIST_OFFSET) % STATE_WORDS;
      y = {gen_words[k][31], gen_words[nxt][30:0]};
      gen_words[k] = gen_words[far] ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
    end
    gen_pos = 0;
    n_twists++;
  endfunction

  function automatic logic [31:0] shape_word(input logic [31:0] w);
    logic [31:0] t;
    t = w ^ (w >> 11);
    t = t ^ ((t << 7) & TEMPER_B);
    t = t ^ ((t << 15) & TEMPER_C);
    return t ^ (t >> 18);
  endfunction

  function automatic logic [31:0] next_word();
    logic [31:0] w;
    if (gen_pos >= STATE_WORDS) begin
      twist_all();
    end
    w = gen_words[gen_pos];
    gen_pos++;
    return shape_word(w);
  endfunction

  function automatic void reseed(input logic [31:0] s);
    logic [31:0] p;
    gen_words[0] = s;
    for (int i = 1; i < STATE_WORDS; i++) begin
      p = gen_words[i-1];
      gen_words[i] = INIT_MULT * (p ^ (p >> INIT_SHIFT)) + 32'(i);
    end
    gen_pos = STATE_WORDS;
    gen_seeded = 1'b1;
    for (int i = 0; i < WARMUP_DRAWS_DEF; i++) begin
      void'(next_word());
    end
  endfunction

  function automatic void advance_generator(input mtrwg_req_t req);
    mtrwg_res_t due;
    if (req.req_type == REQ_SEED) begin
      n_seeds++;
      if (req.seed_value[31]) begin
        n_tick_seeds++;
        reseed({5'd0, req.tick_value});
      end else begin
        reseed(req.seed_value);
      end
    end else begin
      n_draws++;
      due.random_word = '0;
      due.not_seeded  = 1'b1;
      if (gen_seeded) begin
        due.random_word = next_word();
        due.not_seeded  = 1'b0;
      end else begin
        n_unseeded++;
      end
      words_due.push_back(due);
    end
  endfunction

  function automatic mtrwg_req_t build_req(input logic kind, input logic [31:0] seed,
                                           input logic [26:0] tick);
    mtrwg_req_t req;
    req.req_type   = kind;
    req.seed_value = seed;
    req.tick_value = tick;
    return req;
  endfunction

  function automatic mtrwg_req_t random_req(input logic kind);
    return build_req(kind, $urandom(), 27'($urandom()));
  endfunction

  task automatic send_req(input mtrwg_req_t req);
    if (lead_gap > 0) begin
      repeat (lead_gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    advance_generator(req);
    lead_gap = idle_gap();
    if (lead_gap > 0) begin
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    if (lead_gap == 0) begin
      in_valid <= 1'b0;
      lead_gap = 1;
    end
    while (words_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin : drive_out_ready
    int g;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        out_ready <= 1'b1;
      end else begin
        g = idle_gap();
        if (g > 0) begin
          out_ready <= 1'b0;
          repeat (g) @(posedge clk);
        end
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_words
    mtrwg_res_t due;
    if (rst_n && out_valid && out_ready) begin
      if (words_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual word %h not_seeded %b",
                 $time, out_data.random_word, out_data.not_seeded);
      end else begin
        due = words_due.pop_front();
        n_checked++;
        if (out_data.random_word !== due.random_word) begin
          errors++;
          $display("%0t: random_word mismatch, expected %h actual %h",
                   $time, due.random_word, out_data.random_word);
        end
        if (out_data.not_seeded !== due.not_seeded) begin
          errors++;
          $display("%0t: not_seeded mismatch, expected %b actual %b",
                   $time, due.not_seeded, out_data.not_seeded);
        end
      end
    end
  end

  task automatic test_draw_before_seed();
    idle_on = 1'b0;
    send_req(build_req(REQ_DRAW, 32'h7FFF_FFFF, 27'h7FF_FFFF));
    send_req(build_req(REQ_DRAW, 32'h8000_0000, 27'd0));
    send_req(build_req(REQ_DRAW, 32'd0, 27'd86399999));
    wait_drained();
  endtask

  task automatic test_seed_extremes();
    idle_on = 1'b1;
    send_req(build_req(REQ_SEED, 32'd0, 27'h7FF_FFFF));
    send_req(build_req(REQ_DRAW, 32'hFFFF_FFFF, 27'd0));
    send_req(build_req(REQ_DRAW, 32'd0, 27'h7FF_FFFF));
    send_req(build_req(REQ_SEED, 32'h7FFF_FFFF, 27'd0));
    send_req(build_req(REQ_DRAW, 32'd0, 27'd0));
    send_req(build_req(REQ_DRAW, 32'd0, 27'd0));
    send_req(build_req(REQ_SEED, 32'h8000_0000, 27'd0));
    send_req(build_req(REQ_DRAW, 32'd0, 27'd0));
    send_req(build_req(REQ_SEED, 32'hFFFF_FFFF, 27'h7FF_FFFF));
    send_req(build_req(REQ_DRAW, 32'd0, 27'd0));
    send_req(build_req(REQ_SEED, 32'hFFFF_FFFB, 27'd86399999));
    send_req(build_req(REQ_DRAW, 32'd0, 27'd0));
    send_req(build_req(REQ_SEED, 32'd5489, 27'd12345));
    send_req(build_req(REQ_SEED, 32'd1, 27'd0));
    send_req(build_req(REQ_DRAW, 32'h5555_5555, 27'h2AA_AAAA));
    send_req(build_req(REQ_DRAW, 32'hAAAA_AAAA, 27'h555_5555));
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    idle_on = 1'b0;
    send_req(random_req(REQ_SEED));
    hold_cycles = 400;
    for (int i = 0; i < 20; i++) begin
      send_req(random_req(REQ_DRAW));
    end
    wait_drained();
  endtask

  task automatic test_long_stream();
    send_req(random_req(REQ_SEED));
    for (int i = 0; i < 600; i++) begin
      idle_on = ((i / 100) % 2) == 0;
      if (i == 300) begin
        wait_drained();
      end
      send_req(random_req(REQ_DRAW));
    end
    wait_drained();
  endtask

  task automatic test_random_mix();
    idle_on = 1'b1;
    for (int i = 0; i < 80; i++) begin
      send_req(random_req(($urandom_range(0, 99) < 8) ? REQ_SEED : REQ_DRAW));
    end
    wait_drained();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    idle_on     = 1'b0;
    lead_gap    = 1;
    hold_cycles = 0;
    gen_pos     = STATE_WORDS;
    gen_seeded  = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_draw_before_seed();
    test_seed_extremes();
    test_output_backpressure();
    test_long_stream();
    test_random_mix();

    repeat (1500) @(posedge clk);
    if (words_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected beats never arrived", $time, words_due.size());
    end
    $display("Run covered %0d draws (%0d before any seed) and %0d seeds (%0d from tick).",
             n_draws, n_unseeded, n_seeds, n_tick_seeds);
    $display("Model twisted the state %0d times; %0d result beats compared.",
             n_twists, n_checked);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout at %0t", $time);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
